[rtl/trtd_pkg.sv]
`timescale 1ns / 1ps
// shared widths, register codes and interface structs of the tile rasterizer
// no dependencies

package trtd_pkg;

   localparam int EW        = 37;   // signed edge value width
   localparam int RW        = 38;   // divider remainder width
   localparam int WW        = 17;   // weight width, q1.16 with one = 65536
   localparam int ZW        = 16;   // depth width
   localparam int CW        = 16;   // coordinate width, signed 12.4
   localparam int OW        = 12;   // tile origin width
   localparam int AW        = 6;    // depth store address width
   localparam int DEPTH_N   = 64;
   localparam int DIV_STEPS = 17;

   localparam logic [ZW-1:0] DEPTH_FAR = '1;

   localparam logic CSR_ORIGIN_X = 1'b0;
   localparam logic CSR_ORIGIN_Y = 1'b1;

   typedef struct packed {
      logic                    start;
      logic [2:0][EW-1:0]      edge_val;
      logic [EW-1:0]           area;
   } div_req_type;

   typedef struct packed {
      logic                    busy;
      logic [2:0][WW-1:0]      weight;
   } div_rsp_type;

   typedef struct packed {
      logic                    clear;
      logic                    rd_en;
      logic                    wr_en;
      logic [AW-1:0]           addr;
      logic [ZW-1:0]           wr_data;
   } mem_req_type;

endpackage

[rtl/trtd_if.sv]
`timescale 1ns / 1ps
// valid/ready channels for triangle words and fragment words
// depends on trtd_pkg

interface trtd_req_if import trtd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  new_tile;
   logic signed [CW-1:0]  v0_x;
   logic signed [CW-1:0]  v0_y;
   logic [ZW-1:0]         v0_z;
   logic signed [CW-1:0]  v1_x;
   logic signed [CW-1:0]  v1_y;
   logic [ZW-1:0]         v1_z;
   logic signed [CW-1:0]  v2_x;
   logic signed [CW-1:0]  v2_y;
   logic [ZW-1:0]         v2_z;

   modport source (output valid, new_tile, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                   v2_x, v2_y, v2_z, input ready);
   modport sink (input valid, new_tile, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                 v2_x, v2_y, v2_z, output ready);
endinterface

interface trtd_rsp_if import trtd_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [2:0]     pix_x;
   logic [2:0]     pix_y;
   logic [ZW-1:0]  frag_depth;
   logic [WW-1:0]  weight0;
   logic [WW-1:0]  weight1;
   logic [WW-1:0]  weight2;
   logic           last;

   modport source (output valid, pix_x, pix_y, frag_depth, weight0, weight1, weight2,
                   last, input ready);
   modport sink (input valid, pix_x, pix_y, frag_depth, weight0, weight1, weight2,
                 last, output ready);
endinterface

[rtl/trtd_divider.sv]
`timescale 1ns / 1ps
// three-lane restoring divider, one quotient bit per cycle, shared divisor
// computes floor(edge * 65536 / area) for edge <= area; depends on trtd_pkg

module trtd_divider import trtd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output div_rsp_type  rsp
);

   logic                  busy_ff, busy_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [RW-1:0]         div_ff, div_in;
   logic [2:0][RW-1:0]    rem_ff, rem_in;
   logic [2:0][WW-1:0]    quo_ff, quo_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = RW'(req.area);
         for (int k = 0; k < 3; k++) begin
            rem_in[k] = RW'(req.edge_val[k]);
            quo_in[k] = '0;
         end
      end else if (busy_ff) begin
         for (int k = 0; k < 3; k++) begin
            if (rem_ff[k] >= div_ff) begin
               rem_in[k] = (rem_ff[k] - div_ff) << 1;
               quo_in[k] = {quo_ff[k][WW-2:0], 1'b1};
            end else begin
               rem_in[k] = rem_ff[k] << 1;
               quo_in[k] = {quo_ff[k][WW-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.weight = quo_ff;

endmodule

[rtl/trtd_depth_mem.sv]
`timescale 1ns / 1ps
// tile depth store: synchronous memory with registered read and per-entry valid bits
// an entry that is not valid reads as far; depends on trtd_pkg

module trtd_depth_mem import trtd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mem_req_type   req,
   output logic [ZW-1:0] rd_depth
);

   logic [ZW-1:0]       mem [DEPTH_N];
   logic [DEPTH_N-1:0]  valid_ff;
   logic [ZW-1:0]       rd_data_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.clear) begin
            valid_ff <= '0;
         end else if (req.wr_en) begin
            valid_ff[req.addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.addr];
         end
      end
   end

   assign rd_depth = rd_valid_ff ? rd_data_ff : DEPTH_FAR;

endmodule

[rtl/tile_triangle_raster_depth_test.sv]
`timescale 1ns / 1ps
// tile triangle rasterizer with depth test, top level
// depends on trtd_pkg, trtd_if, trtd_divider, trtd_depth_mem
//
//   channel  dir  handshake              words
//   req_ch   in   valid/ready            one triangle
//   rsp_ch   out  valid/ready            one fragment each
//   csr_     in   apb write/read         tile origin x, y
//
// setup runs first, then pixels go in row-major order: an uncovered pixel is skipped, a
// covered one waits on the divider and is then depth tested, and one that passes is
// written to the depth store and pushed out as a fragment.
// a degenerate triangle, of zero area, goes back to idle after setup with no pixels.
// reset is synchronous and sets the depth store to far through its valid bits.
// a fragment is held one step so that last can be marked; rsp stalls hold the walk.

module tile_triangle_raster_depth_test import trtd_pkg::*; #(
   parameter int TILE_SIZE = 8
) (
   input  logic               clock,
   input  logic               reset,
   trtd_req_if.sink           req_ch,
   trtd_rsp_if.source         rsp_ch,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic [2:0] LAST_POS = 3'(TILE_SIZE - 1);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_DIFF  = 11'b00000000010,
      ST_MUL   = 11'b00000000100,
      ST_EDGE  = 11'b00000001000,
      ST_AREA  = 11'b00000010000,
      ST_PIXEL = 11'b00000100000,
      ST_DIV   = 11'b00001000000,
      ST_ZMUL  = 11'b00010000000,
      ST_TEST  = 11'b00100000000,
      ST_PUSH  = 11'b01000000000,
      ST_FLUSH = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [OW-1:0] org_x_ff, org_y_ff;

   logic signed [CW-1:0] vx_ff [3];
   logic signed [CW-1:0] vy_ff [3];
   logic [ZW-1:0]        vz_ff [3];

   logic signed [CW:0]   dx_ff [3];
   logic signed [CW:0]   dy_ff [3];
   logic signed [CW+1:0] qx_ff [3];
   logic signed [CW+1:0] qy_ff [3];
   logic signed [34:0]   pa_ff [3];
   logic signed [34:0]   pb_ff [3];
   logic signed [EW-1:0] erow_ff [3];
   logic signed [EW-1:0] ecur_ff [3];
   logic signed [EW-1:0] erow_in [3];
   logic signed [EW-1:0] ecur_in [3];
   logic signed [EW-1:0] area_ff;
   logic signed [EW-1:0] area_sum;

   logic [2:0]    px_ff, py_ff, px_in, py_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [32:0]   pz_ff [3];
   logic [34:0]   zsum;
   logic [ZW-1:0] depth;

   logic [2:0]    cand_x_ff, cand_y_ff;
   logic [ZW-1:0] cand_d_ff;
   logic [2:0][WW-1:0] cand_w_ff;

   logic          pend_ff, pend_in;
   logic [2:0]    pend_x_ff, pend_y_ff;
   logic [ZW-1:0] pend_d_ff;
   logic [2:0][WW-1:0] pend_w_ff;

   logic          out_valid_ff, out_valid_in;
   logic [2:0]    out_x_ff, out_y_ff;
   logic [ZW-1:0] out_d_ff;
   logic [2:0][WW-1:0] out_w_ff;
   logic          out_last_ff;

   logic          accept, out_free, covered, adv, tile_end, pass;
   logic          load_out, load_pend;

   div_req_type   div_req;
   div_rsp_type   div_rsp;
   mem_req_type   mem_req;
   logic [ZW-1:0] stored;

   // configuration port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            CSR_ORIGIN_X: org_x_ff <= csr_pwdata[OW-1:0];
            CSR_ORIGIN_Y: org_y_ff <= csr_pwdata[OW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_ORIGIN_X: csr_prdata = 32'(org_x_ff);
         CSR_ORIGIN_Y: csr_prdata = 32'(org_y_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   assign covered  = !ecur_ff[0][EW-1] && !ecur_ff[1][EW-1] && !ecur_ff[2][EW-1];
   assign tile_end = (px_ff == LAST_POS) && (py_ff == LAST_POS);
   assign area_sum = erow_ff[0] + erow_ff[1] + erow_ff[2];

   always_comb begin
      zsum = 35'(pz_ff[0]) + 35'(pz_ff[1]) + 35'(pz_ff[2]);
      depth = zsum[31:16];
   end
   assign pass = (depth <= stored);

   // walk to the next pixel with incremental edge values
   always_comb begin
      px_in   = px_ff;
      py_in   = py_ff;
      addr_in = addr_ff;
      for (int k = 0; k < 3; k++) begin
         erow_in[k] = erow_ff[k];
         ecur_in[k] = ecur_ff[k];
      end
      if (px_ff == LAST_POS) begin
         px_in   = '0;
         py_in   = py_ff + 3'd1;
         addr_in = addr_ff + AW'(1);
         for (int k = 0; k < 3; k++) begin
            erow_in[k] = erow_ff[k] + (EW'(dx_ff[k]) <<< 4);
            ecur_in[k] = erow_ff[k] + (EW'(dx_ff[k]) <<< 4);
         end
      end else begin
         px_in   = px_ff + 3'd1;
         addr_in = addr_ff + AW'(1);
         for (int k = 0; k < 3; k++) begin
            ecur_in[k] = ecur_ff[k] - (EW'(dy_ff[k]) <<< 4);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      adv          = 1'b0;
      load_out     = 1'b0;
      load_pend    = 1'b0;
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_EDGE;
         ST_EDGE:  state_in = ST_AREA;
         ST_AREA:  state_in = (area_sum == '0) ? ST_IDLE : ST_PIXEL;
         ST_PIXEL: begin
            if (covered) begin
               state_in = ST_DIV;
            end else begin
               adv = 1'b1;
            end
         end
         ST_DIV:   if (!div_rsp.busy) state_in = ST_ZMUL;
         ST_ZMUL:  state_in = ST_TEST;
         ST_TEST:  begin
            if (pass) begin
               state_in = ST_PUSH;
            end else begin
               adv = 1'b1;
            end
         end
         ST_PUSH:  begin
            if (!pend_ff) begin
               load_pend = 1'b1;
               pend_in   = 1'b1;
               adv       = 1'b1;
            end else if (out_free) begin
               load_out     = 1'b1;
               load_pend    = 1'b1;
               out_valid_in = 1'b1;
               adv          = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
      if (adv) begin
         state_in = tile_end ? ST_FLUSH : ST_PIXEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // setup datapath and pixel walk
   always_ff @(posedge clock) begin
      if (accept) begin
         vx_ff[0] <= req_ch.v0_x;  vy_ff[0] <= req_ch.v0_y;  vz_ff[0] <= req_ch.v0_z;
         vx_ff[1] <= req_ch.v1_x;  vy_ff[1] <= req_ch.v1_y;  vz_ff[1] <= req_ch.v1_z;
         vx_ff[2] <= req_ch.v2_x;  vy_ff[2] <= req_ch.v2_y;  vz_ff[2] <= req_ch.v2_z;
      end
      if (state_ff == ST_DIFF) begin
         for (int k = 0; k < 3; k++) begin
            dx_ff[k] <= (CW+1)'(vx_ff[(k + 2) % 3]) - (CW+1)'(vx_ff[(k + 1) % 3]);
            dy_ff[k] <= (CW+1)'(vy_ff[(k + 2) % 3]) - (CW+1)'(vy_ff[(k + 1) % 3]);
            qx_ff[k] <= $signed({2'b00, org_x_ff, 4'b0000})
                        - (CW+2)'(vx_ff[(k + 1) % 3]);
            qy_ff[k] <= $signed({2'b00, org_y_ff, 4'b0000})
                        - (CW+2)'(vy_ff[(k + 1) % 3]);
         end
      end
      if (state_ff == ST_MUL) begin
         for (int k = 0; k < 3; k++) begin
            pa_ff[k] <= dx_ff[k] * qy_ff[k];
            pb_ff[k] <= qx_ff[k] * dy_ff[k];
         end
      end
      if (state_ff == ST_EDGE) begin
         for (int k = 0; k < 3; k++) begin
            erow_ff[k] <= EW'(pa_ff[k]) - EW'(pb_ff[k]);
            ecur_ff[k] <= EW'(pa_ff[k]) - EW'(pb_ff[k]);
         end
         px_ff   <= '0;
         py_ff   <= '0;
         addr_ff <= '0;
      end else if (adv) begin
         for (int k = 0; k < 3; k++) begin
            erow_ff[k] <= erow_in[k];
            ecur_ff[k] <= ecur_in[k];
         end
         px_ff   <= px_in;
         py_ff   <= py_in;
         addr_ff <= addr_in;
      end
      if (state_ff == ST_AREA) begin
         area_ff <= area_sum;
      end
      if (state_ff == ST_ZMUL) begin
         for (int k = 0; k < 3; k++) begin
            pz_ff[k] <= 33'(div_rsp.weight[k]) * 33'(vz_ff[k]);
         end
      end
      if (state_ff == ST_TEST) begin
         cand_x_ff <= px_ff;
         cand_y_ff <= py_ff;
         cand_d_ff <= depth;
         cand_w_ff <= div_rsp.weight;
      end
      if (load_pend) begin
         pend_x_ff <= cand_x_ff;
         pend_y_ff <= cand_y_ff;
         pend_d_ff <= cand_d_ff;
         pend_w_ff <= cand_w_ff;
      end
      if (load_out) begin
         out_x_ff    <= pend_x_ff;
         out_y_ff    <= pend_y_ff;
         out_d_ff    <= pend_d_ff;
         out_w_ff    <= pend_w_ff;
         out_last_ff <= (state_ff == ST_FLUSH);
      end
   end

   // divider and depth store
   always_comb begin
      div_req.start = (state_ff == ST_PIXEL) && covered;
      for (int k = 0; k < 3; k++) begin
         div_req.edge_val[k] = ecur_ff[k];
      end
      div_req.area = area_ff;

      mem_req.clear   = accept && req_ch.new_tile;
      mem_req.rd_en   = (state_ff == ST_PIXEL) && covered;
      mem_req.wr_en   = (state_ff == ST_TEST) && pass;
      mem_req.addr    = addr_ff;
      mem_req.wr_data = depth;
   end

   trtd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   trtd_depth_mem u_depth_mem (
      .clock    (clock),
      .reset    (reset),
      .req      (mem_req),
      .rd_depth (stored)
   );

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pix_x      = out_x_ff;
   assign rsp_ch.pix_y      = out_y_ff;
   assign rsp_ch.frag_depth = out_d_ff;
   assign rsp_ch.weight0    = out_w_ff[0];
   assign rsp_ch.weight1    = out_w_ff[1];
   assign rsp_ch.weight2    = out_w_ff[2];
   assign rsp_ch.last       = out_last_ff;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the tile triangle rasterizer with depth test
// depends on trtd_pkg, trtd_if and the tile_triangle_raster_depth_test rtl

module tb_top import trtd_pkg::*; ();

   localparam int TILE = 8;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic               new_tile;
      logic signed [15:0] v0_x;
      logic signed [15:0] v0_y;
      logic [15:0]        v0_z;
      logic signed [15:0] v1_x;
      logic signed [15:0] v1_y;
      logic [15:0]        v1_z;
      logic signed [15:0] v2_x;
      logic signed [15:0] v2_y;
      logic [15:0]        v2_z;
   } triangle_type;

   typedef struct packed {
      logic [2:0]    pix_x;
      logic [2:0]    pix_y;
      logic [15:0]   frag_depth;
      logic [WW-1:0] weight0;
      logic [WW-1:0] weight1;
      logic [WW-1:0] weight2;
      logic          last;
   } fragment_type;

   typedef struct {
      triangle_type shape;
      int           frags;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   trtd_req_if req_ch ();
   trtd_rsp_if rsp_ch ();

   tile_triangle_raster_depth_test #(.TILE_SIZE(TILE)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   logic [15:0]  depth_shadow [64];
   logic [11:0]  origin_x;
   logic [11:0]  origin_y;
   fragment_type frag_queue [$];
   int           fail_count;
   int           frags_seen;
   longint       cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py);
      return (bx - ax) * (py - ay) - (px - ax) * (by - ay);
   endfunction

   function automatic int raster_triangle(triangle_type t);
      longint       ax, ay, bx, by, cx, cy, px, py, e0, e1, e2, s;
      longint       w0, w1, w2, d;
      int           idx, count;
      fragment_type f;
      ax = t.v0_x; ay = t.v0_y;
      bx = t.v1_x; by = t.v1_y;
      cx = t.v2_x; cy = t.v2_y;
      count = 0;
      if (t.new_tile)
         foreach (depth_shadow[i]) depth_shadow[i] = DEPTH_FAR;
      for (int y = 0; y < TILE; y++) begin
         for (int x = 0; x < TILE; x++) begin
            px = (longint'(origin_x) + x) * 16;
            py = (longint'(origin_y) + y) * 16;
            e0 = edge_fn(bx, by, cx, cy, px, py);
            e1 = edge_fn(cx, cy, ax, ay, px, py);
            e2 = edge_fn(ax, ay, bx, by, px, py);
            s = e0 + e1 + e2;
            if (s == 0) return 0;
            if (e0 < 0 || e1 < 0 || e2 < 0) continue;
            w0 = (e0 * 65536) / s;
            w1 = (e1 * 65536) / s;
            w2 = (e2 * 65536) / s;
            d = (w0 * t.v0_z + w1 * t.v1_z + w2 * t.v2_z) >> 16;
            idx = y * TILE + x;
            if (d > depth_shadow[idx]) continue;
            depth_shadow[idx] = d[15:0];
            f.pix_x = x[2:0];
            f.pix_y = y[2:0];
            f.frag_depth = d[15:0];
            f.weight0 = w0[WW-1:0];
            f.weight1 = w1[WW-1:0];
            f.weight2 = w2[WW-1:0];
            f.last = 1'b0;
            frag_queue.push_back(f);
            count++;
         end
      end
      if (count > 0) frag_queue[$].last = 1'b1;
      return count;
   endfunction

   // result checker
   always @(posedge clock) begin
      fragment_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         frags_seen <= frags_seen + 1;
         if (frag_queue.size() == 0) begin
            $error("unexpected fragment x=%0d y=%0d", rsp_ch.pix_x, rsp_ch.pix_y);
            fail_count++;
         end else begin
            e = frag_queue.pop_front();
            if (rsp_ch.pix_x !== e.pix_x) begin
               $error("pix_x exp %0d got %0d", e.pix_x, rsp_ch.pix_x); fail_count++;
            end
            if (rsp_ch.pix_y !== e.pix_y) begin
               $error("pix_y exp %0d got %0d", e.pix_y, rsp_ch.pix_y); fail_count++;
            end
            if (rsp_ch.frag_depth !== e.frag_depth) begin
               $error("frag_depth exp %0d got %0d", e.frag_depth, rsp_ch.frag_depth);
               fail_count++;
            end
            if (rsp_ch.weight0 !== e.weight0) begin
               $error("weight0 exp %0d got %0d", e.weight0, rsp_ch.weight0); fail_count++;
            end
            if (rsp_ch.weight1 !== e.weight1) begin
               $error("weight1 exp %0d got %0d", e.weight1, rsp_ch.weight1); fail_count++;
            end
            if (rsp_ch.weight2 !== e.weight2) begin
               $error("weight2 exp %0d got %0d", e.weight2, rsp_ch.weight2); fail_count++;
            end
            if (rsp_ch.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_ch.last); fail_count++;
            end
         end
      end
   end

   // fragment receiver with one long hold-off
   initial begin
      bit held;
      int n;
      held = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && frags_seen >= 20) begin
            held = 1;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_ch.ready <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic csr_write(logic idx, logic [11:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {20'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ORIGIN_X) origin_x = value;
      else origin_y = value;
   endtask

   task automatic send_triangle(triangle_type t, int frags_typed);
      int n, gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.new_tile <= t.new_tile;
      req_ch.v0_x <= t.v0_x; req_ch.v0_y <= t.v0_y; req_ch.v0_z <= t.v0_z;
      req_ch.v1_x <= t.v1_x; req_ch.v1_y <= t.v1_y; req_ch.v1_z <= t.v1_z;
      req_ch.v2_x <= t.v2_x; req_ch.v2_y <= t.v2_y; req_ch.v2_z <= t.v2_z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n = raster_triangle(t);
      if (frags_typed >= 0 && n != frags_typed) begin
         $error("fragment count exp %0d got %0d", frags_typed, n);
         fail_count++;
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (frag_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic logic signed [15:0] near_coord(int base);
      int v;
      v = base + int'($urandom_range(0, 400)) - 150;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type       t;
      longint             s;
      logic signed [15:0] tx, ty;
      logic [159:0]       raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(triangle_type)-1:0];
      t.new_tile = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) begin
         t.v0_x = near_coord(origin_x * 16); t.v0_y = near_coord(origin_y * 16);
         t.v1_x = near_coord(origin_x * 16); t.v1_y = near_coord(origin_y * 16);
         t.v2_x = near_coord(origin_x * 16); t.v2_y = near_coord(origin_y * 16);
         s = edge_fn(t.v0_x, t.v0_y, t.v1_x, t.v1_y, t.v2_x, t.v2_y);
         if (s < 0 && $urandom_range(0, 9) != 0) begin
            tx = t.v1_x; ty = t.v1_y;
            t.v1_x = t.v2_x; t.v1_y = t.v2_y;
            t.v2_x = tx; t.v2_y = ty;
         end
      end
      return t;
   endfunction

   initial begin
      directed_row_type rows [8];
      logic [11:0] ox [5];
      logic [11:0] oy [5];
      rows[0] = '{'{1'b1, -16'sd1000, -16'sd1000, 16'd0, 16'sd5000, -16'sd1000, 16'd0,
                   -16'sd1000, 16'sd5000, 16'd0}, 64};
      rows[1] = '{'{1'b0, -16'sd1000, -16'sd1000, 16'hffff, 16'sd5000, -16'sd1000,
                   16'hffff, -16'sd1000, 16'sd5000, 16'hffff}, 0};
      rows[2] = '{'{1'b0, 16'sd100, 16'sd100, 16'd500, 16'sd100, 16'sd100, 16'd600,
                   16'sd100, 16'sd100, 16'd700}, 0};
      rows[3] = '{'{1'b1, -16'sd1000, -16'sd1000, 16'd0, -16'sd1000, 16'sd5000, 16'd0,
                   16'sd5000, -16'sd1000, 16'd0}, 0};
      rows[4] = '{'{1'b0, -16'sd1000, -16'sd1000, 16'd0, 16'sd5000, -16'sd1000, 16'd0,
                   -16'sd1000, 16'sd5000, 16'd0}, 64};
      rows[5] = '{'{1'b1, 16'sh8000, 16'sh8000, 16'hffff, 16'sd32767, 16'sh8000,
                   16'd0, 16'sh8000, 16'sd32767, 16'd12345}, -1};
      rows[6] = '{'{1'b0, 16'sd32767, 16'sd32767, 16'hffff, 16'sh8000, 16'sd32767,
                   16'hffff, 16'sd32767, 16'sh8000, 16'hffff}, -1};
      rows[7] = '{'{1'b1, 16'sd0, 16'sd0, 16'd40000, 16'sd112, 16'sd0, 16'd20000,
                   16'sd0, 16'sd112, 16'd0}, -1};
      ox = '{12'd0, 12'd4095, 12'd2040, 12'd0, 12'd0};
      oy = '{12'd0, 12'd4095, 12'd0, 12'd2040, 12'd0};

      cycles = 0;
      fail_count = 0;
      frags_seen = 0;
      foreach (depth_shadow[i]) depth_shadow[i] = DEPTH_FAR;
      origin_x = '0;
      origin_y = '0;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.new_tile = 1'b0;
      req_ch.v0_x = '0; req_ch.v0_y = '0; req_ch.v0_z = '0;
      req_ch.v1_x = '0; req_ch.v1_y = '0; req_ch.v1_z = '0;
      req_ch.v2_x = '0; req_ch.v2_y = '0; req_ch.v2_z = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_triangle(rows[i].shape, rows[i].frags);
      drain();

      for (int p = 0; p < 6; p++) begin
         if (p < 5) begin
            csr_write(CSR_ORIGIN_X, ox[p]);
            csr_write(CSR_ORIGIN_Y, oy[p]);
         end else begin
            csr_write(CSR_ORIGIN_X, 12'($urandom_range(0, 2040)));
            csr_write(CSR_ORIGIN_Y, 12'($urandom_range(0, 2040)));
         end
         repeat ((p == 1) ? 10 : 48) send_triangle(random_triangle(), -1);
         drain();
      end

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
